// ===== hdl/saa_pkg.sv =====
// Shared types, constants and tables for the splat attribute activation unit.
package saa_pkg;

    localparam int EXP_STAGES = 15;
    localparam int DIV_STAGES = 17;
    localparam int PIPE_DEPTH = EXP_STAGES + DIV_STAGES;

    localparam int Q24_FRAC = 24;
    localparam int EXP_PW = 30;
    localparam int EXP_OW = 36;

    localparam int QUOT_W = 16;
    localparam int DIV_DW = 26;
    localparam int DIV_RW = 41;

    localparam int SCALE_SHIFT = 12;
    localparam int COLOR_SHIFT = 13;

    localparam logic [EXP_OW-1:0] Q24_ONE = EXP_OW'(36'd16777216);
    localparam logic [EXP_OW-1:0] EXP_NEG8_Q24 = EXP_OW'(36'd5628);
    localparam logic [2*EXP_PW-1:0] EXP_ROUND = (2*EXP_PW)'(1) << (Q24_FRAC - 1);
    localparam logic [EXP_OW:0] SCALE_ROUND = (EXP_OW + 1)'(1) << (SCALE_SHIFT - 1);
    localparam logic [23:0] SCALE_MAX = 24'hFF_FFFF;
    localparam logic [15:0] UNIT_Q15 = 16'd32768;
    localparam logic signed [31:0] SH0_Q16 = 32'sd18487;
    localparam logic signed [31:0] COLOR_BIAS = 32'sd134221824;
    localparam logic [DIV_RW-1:0] RECIP_BIAS =
        (DIV_RW'(1) << 39) + (DIV_RW'(1) << (Q24_FRAC - 1));

    localparam logic [EXP_PW-1:0] EXP_FACTOR [EXP_STAGES] = '{
        30'd16781313, 30'd16785410, 30'd16793608, 30'd16810016, 30'd16842880,
        30'd16908801, 30'd17041419, 30'd17309782, 30'd17859253, 30'd19011076,
        30'd21542372, 30'd27660953, 30'd45605201, 30'd123967790, 30'd916004956
    };

    typedef struct packed {
        logic signed [15:0] log_scale_x;
        logic signed [15:0] log_scale_y;
        logic signed [15:0] log_scale_z;
        logic signed [15:0] dc_red;
        logic signed [15:0] dc_green;
        logic signed [15:0] dc_blue;
        logic signed [15:0] opacity_logit;
    } t_splat_in;

    typedef struct packed {
        logic [23:0] scale_x;
        logic [23:0] scale_y;
        logic [23:0] scale_z;
        logic [15:0] red;
        logic [15:0] green;
        logic [15:0] blue;
        logic [15:0] alpha;
    } t_splat_out;

endpackage

// ===== hdl/saa_exp_lane.sv =====
// Pipelined fixed-point exponential: one rounded Q24 multiply per input bit below the sign bit.
module saa_exp_lane (
    input  logic                       i_clk,
    input  logic                       i_en,
    input  logic [15:0]                i_pat,
    output logic [saa_pkg::EXP_OW-1:0] o_exp
);
    import saa_pkg::*;

    logic [EXP_PW-1:0] r_p [EXP_STAGES-1];
    logic [15:0]       r_pat [EXP_STAGES-1];
    logic [EXP_OW-1:0] r_last;

    logic [EXP_PW-1:0] w_p_in [EXP_STAGES];
    logic [15:0]       w_pat_in [EXP_STAGES];
    logic [EXP_OW-1:0] w_p_out [EXP_STAGES];

    assign w_p_in[0]   = i_pat[15] ? EXP_PW'(EXP_NEG8_Q24) : EXP_PW'(Q24_ONE);
    assign w_pat_in[0] = i_pat;

    for (genvar s = 1; s < EXP_STAGES; s++) begin : g_link
        assign w_p_in[s]   = r_p[s-1];
        assign w_pat_in[s] = r_pat[s-1];
    end

    for (genvar s = 0; s < EXP_STAGES; s++) begin : g_stage
        logic [2*EXP_PW-1:0] w_prod;
        assign w_prod = (2*EXP_PW)'(w_p_in[s]) * (2*EXP_PW)'(EXP_FACTOR[s]) + EXP_ROUND;
        assign w_p_out[s] = w_pat_in[s][s] ? w_prod[Q24_FRAC +: EXP_OW]
                                           : EXP_OW'(w_p_in[s]);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int s = 0; s < EXP_STAGES - 1; s++) begin
                r_p[s]   <= w_p_out[s][EXP_PW-1:0];
                r_pat[s] <= w_pat_in[s];
            end
            r_last <= w_p_out[EXP_STAGES-1];
        end
    end

    assign o_exp = r_last;

endmodule

// ===== hdl/saa_recip_div.sv =====
// Pipelined restoring divider that forms the rounded Q15 reciprocal of one plus exp.
module saa_recip_div (
    input  logic                       i_clk,
    input  logic                       i_en,
    input  logic [saa_pkg::EXP_OW-1:0] i_exp,
    output logic [saa_pkg::QUOT_W-1:0] o_quot
);
    import saa_pkg::*;

    logic [DIV_DW-1:0] r_d0;
    logic [DIV_RW-1:0] r_n;
    logic [DIV_RW-1:0] r_rem [QUOT_W-1];
    logic [DIV_DW-1:0] r_dv [QUOT_W-1];
    logic [QUOT_W-1:0] r_q [QUOT_W];

    logic [DIV_RW-1:0] w_rem_in [QUOT_W];
    logic [DIV_RW-1:0] w_rem_out [QUOT_W];
    logic [DIV_DW-1:0] w_d_in [QUOT_W];
    logic [QUOT_W-1:0] w_q_in [QUOT_W];
    logic [QUOT_W-1:0] w_q_out [QUOT_W];

    assign w_rem_in[0] = r_n;
    assign w_d_in[0]   = r_d0;
    assign w_q_in[0]   = '0;

    for (genvar j = 1; j < QUOT_W; j++) begin : g_link
        assign w_rem_in[j] = r_rem[j-1];
        assign w_d_in[j]   = r_dv[j-1];
        assign w_q_in[j]   = r_q[j-1];
    end

    for (genvar j = 0; j < QUOT_W; j++) begin : g_stage
        localparam int K = QUOT_W - 1 - j;
        logic [DIV_RW:0] w_sub;
        assign w_sub = {1'b0, w_rem_in[j]} - {1'b0, DIV_RW'(w_d_in[j]) << K};
        assign w_rem_out[j] = w_sub[DIV_RW] ? w_rem_in[j] : w_sub[DIV_RW-1:0];
        assign w_q_out[j] = w_q_in[j] | (QUOT_W'(!w_sub[DIV_RW]) << K);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_d0 <= DIV_DW'(Q24_ONE) + DIV_DW'(i_exp[Q24_FRAC:0]);
            r_n  <= RECIP_BIAS + DIV_RW'(i_exp[Q24_FRAC:1]);
            for (int j = 0; j < QUOT_W - 1; j++) begin
                r_rem[j] <= w_rem_out[j];
                r_dv[j]  <= w_d_in[j];
            end
            for (int j = 0; j < QUOT_W; j++) begin
                r_q[j] <= w_q_out[j];
            end
        end
    end

    assign o_quot = r_q[QUOT_W-1];

endmodule

// ===== hdl/saa_color_lane.sv =====
// Color lane: scales a degree-0 harmonic term, adds one half, clamps and delays it.
module saa_color_lane (
    input  logic               i_clk,
    input  logic               i_en,
    input  logic signed [15:0] i_dc,
    output logic [15:0]        o_color
);
    import saa_pkg::*;

    logic signed [31:0] w_ext;
    logic signed [31:0] w_sum;
    logic [17:0]        w_shift;
    logic [15:0]        w_val;
    logic [15:0]        r_dly [PIPE_DEPTH];

    assign w_ext   = {{16{i_dc[15]}}, i_dc};
    assign w_sum   = w_ext * SH0_Q16 + COLOR_BIAS;
    assign w_shift = w_sum[30:COLOR_SHIFT];

    always_comb begin
        if (w_sum[31]) begin
            w_val = '0;
        end else if (w_shift > 18'(UNIT_Q15)) begin
            w_val = UNIT_Q15;
        end else begin
            w_val = w_shift[15:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_dly[0] <= w_val;
            for (int s = 1; s < PIPE_DEPTH; s++) begin
                r_dly[s] <= r_dly[s-1];
            end
        end
    end

    assign o_color = r_dly[PIPE_DEPTH-1];

endmodule

// ===== hdl/saa_out_buf.sv =====
// Two-beat output queue that decouples the lane pipeline from the result channel.
module saa_out_buf (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  saa_pkg::t_splat_out i_data,
    output logic                o_room,
    output logic                o_valid,
    input  logic                i_ready,
    output saa_pkg::t_splat_out o_data
);
    import saa_pkg::*;

    t_splat_out r_main;
    t_splat_out r_skid;
    logic       r_main_vld;
    logic       r_skid_vld;
    logic       w_pop;

    assign w_pop = r_main_vld && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_vld <= 1'b0;
            r_skid_vld <= 1'b0;
        end else if (r_skid_vld) begin
            if (w_pop) begin
                r_main_vld <= 1'b1;
                r_skid_vld <= 1'b0;
            end
        end else if (i_push) begin
            if (r_main_vld && !w_pop) begin
                r_skid_vld <= 1'b1;
            end else begin
                r_main_vld <= 1'b1;
            end
        end else if (w_pop) begin
            r_main_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_vld) begin
            if (w_pop) begin
                r_main <= r_skid;
            end
        end else if (i_push) begin
            if (r_main_vld && !w_pop) begin
                r_skid <= i_data;
            end else begin
                r_main <= i_data;
            end
        end
    end

    assign o_room  = !r_skid_vld;
    assign o_valid = r_main_vld;
    assign o_data  = r_main;

endmodule

// ===== hdl/splat_attribute_activation_unit.sv =====
// Top level of the splat attribute activation unit: lanes, alignment and output queue.
// The unit accepts one splat beat per clock cycle while the output queue has room and
// returns one activated beat for each, in order. A beat reaches the output register after the
// 15-stage multiply chain of each exponential lane, followed by the 17-stage reciprocal divider of
// the opacity lane, with the scale and color lanes delayed to match. On a result stall a
// second output register absorbs one beat, and then the whole pipeline holds.
module splat_attribute_activation_unit (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  saa_pkg::t_splat_in  i_splat,
    output logic                o_valid,
    input  logic                i_ready,
    output saa_pkg::t_splat_out o_attr
);
    import saa_pkg::*;

    logic                  w_en;
    logic                  w_push;
    logic [PIPE_DEPTH-1:0] r_vld;
    logic [PIPE_DEPTH-1:0] r_neg;

    logic [15:0]       w_scale_pat [3];
    logic [EXP_OW-1:0] w_scale_exp [3];
    logic [23:0]       w_scale_val [3];
    logic [23:0]       r_scale_dly [3][DIV_STAGES];

    logic [15:0]       w_alpha_pat;
    logic [EXP_OW-1:0] w_alpha_exp;
    logic [QUOT_W-1:0] w_quot;
    logic [15:0]       w_quot_cap;
    logic [15:0]       w_alpha;
    logic [15:0]       w_red;
    logic [15:0]       w_green;
    logic [15:0]       w_blue;
    t_splat_out        w_result;

    assign o_ready = w_en;
    assign w_push  = w_en && r_vld[PIPE_DEPTH-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[PIPE_DEPTH-2:0], i_valid};
        end
    end

    assign w_scale_pat[0] = i_splat.log_scale_x;
    assign w_scale_pat[1] = i_splat.log_scale_y;
    assign w_scale_pat[2] = i_splat.log_scale_z;

    for (genvar l = 0; l < 3; l++) begin : g_scale
        logic [EXP_OW:0]          w_sum;
        logic [EXP_OW-SCALE_SHIFT:0] w_rnd;

        saa_exp_lane u_exp (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_pat (w_scale_pat[l]),
            .o_exp (w_scale_exp[l])
        );

        assign w_sum = (EXP_OW + 1)'(w_scale_exp[l]) + SCALE_ROUND;
        assign w_rnd = w_sum[EXP_OW:SCALE_SHIFT];
        assign w_scale_val[l] = (w_rnd > (EXP_OW - SCALE_SHIFT + 1)'(SCALE_MAX)) ? SCALE_MAX
                                                                                : w_rnd[23:0];
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int l = 0; l < 3; l++) begin
                r_scale_dly[l][0] <= w_scale_val[l];
                for (int s = 1; s < DIV_STAGES; s++) begin
                    r_scale_dly[l][s] <= r_scale_dly[l][s-1];
                end
            end
        end
    end

    saa_color_lane u_red (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_dc    (i_splat.dc_red),
        .o_color (w_red)
    );

    saa_color_lane u_green (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_dc    (i_splat.dc_green),
        .o_color (w_green)
    );

    saa_color_lane u_blue (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_dc    (i_splat.dc_blue),
        .o_color (w_blue)
    );

    // The sigmoid always works from exp of minus the magnitude of the logit.
    assign w_alpha_pat = i_splat.opacity_logit[15] ? i_splat.opacity_logit
                                                   : 16'(16'd0 - i_splat.opacity_logit);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_neg <= {r_neg[PIPE_DEPTH-2:0], i_splat.opacity_logit[15]};
        end
    end

    saa_exp_lane u_alpha_exp (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_pat (w_alpha_pat),
        .o_exp (w_alpha_exp)
    );

    saa_recip_div u_alpha_div (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_exp  (w_alpha_exp),
        .o_quot (w_quot)
    );

    assign w_quot_cap = (w_quot > UNIT_Q15) ? UNIT_Q15 : w_quot;
    assign w_alpha    = r_neg[PIPE_DEPTH-1] ? 16'(UNIT_Q15 - w_quot_cap) : w_quot_cap;

    assign w_result.scale_x = r_scale_dly[0][DIV_STAGES-1];
    assign w_result.scale_y = r_scale_dly[1][DIV_STAGES-1];
    assign w_result.scale_z = r_scale_dly[2][DIV_STAGES-1];
    assign w_result.red     = w_red;
    assign w_result.green   = w_green;
    assign w_result.blue    = w_blue;
    assign w_result.alpha   = w_alpha;

    saa_out_buf u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_result),
        .o_room  (w_en),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_data  (o_attr)
    );

    a_pipe_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_en |=> $stable(r_vld))
        else $error("Lane pipeline advanced while the output queue was full.");

    a_push_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |=> o_valid)
        else $error("A finished beat did not reach the output register.");

    a_unit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_attr.red <= UNIT_Q15 && o_attr.green <= UNIT_Q15 &&
                     o_attr.blue <= UNIT_Q15 && o_attr.alpha <= UNIT_Q15))
        else $error("Color or alpha exceeds one.");

endmodule

// ===== tb/sv/tb_splat_attribute_activation_unit.sv =====
// Self-checking testbench for the splat attribute activation unit with a scoreboard class.
module tb_splat_attribute_activation_unit;
    import saa_pkg::*;

    localparam int CYCLE_LIMIT = 500000;
    localparam int RANDOM_BEATS = 1750;
    localparam int QUIET_BEATS = 200;
    localparam int DRAIN_CYCLES = 48;

    localparam logic [29:0] EXP_STEP_Q24 [15] = '{
        30'd16781313, 30'd16785410, 30'd16793608, 30'd16810016, 30'd16842880,
        30'd16908801, 30'd17041419, 30'd17309782, 30'd17859253, 30'd19011076,
        30'd21542372, 30'd27660953, 30'd45605201, 30'd123967790, 30'd916004956
    };

    class activation_scoreboard;
        // The newest expected beat sits at the front and the oldest at the back.
        t_splat_out expected_attr[$];
        int unsigned mismatches;

        function logic [63:0] exp_q24(logic [15:0] pat);
            logic [63:0] prod;
            prod = pat[15] ? 64'd5628 : 64'd16777216;
            for (int i = 0; i < 15; i++) begin
                if (pat[i]) begin
                    prod = (prod * 64'(EXP_STEP_Q24[i]) + 64'd8388608) >> 24;
                end
            end
            return prod;
        endfunction

        function logic [23:0] scale_q12(logic [15:0] raw);
            logic [63:0] r;
            r = (exp_q24(raw) + 64'd2048) >> 12;
            return (r > 64'hFF_FFFF) ? 24'hFF_FFFF : r[23:0];
        endfunction

        function logic [15:0] color_q15(logic signed [15:0] c);
            longint s;
            s = longint'(c) * 18487 + 134217728 + 4096;
            if (s < 0) begin
                return 16'd0;
            end
            s = s >>> 13;
            return (s > 32768) ? 16'd32768 : 16'(s);
        endfunction

        function logic [15:0] alpha_q15(logic signed [15:0] x);
            logic [15:0] pat;
            logic [63:0] d;
            logic [63:0] q;
            pat = x[15] ? x : 16'(~x + 16'd1);
            d = 64'd16777216 + exp_q24(pat);
            q = ((64'd1 << 39) + d / 2) / d;
            if (q > 64'd32768) begin
                q = 64'd32768;
            end
            return x[15] ? 16'(64'd32768 - q) : q[15:0];
        endfunction

        function void note_splat(t_splat_in s);
            t_splat_out a;
            a.scale_x = scale_q12(s.log_scale_x);
            a.scale_y = scale_q12(s.log_scale_y);
            a.scale_z = scale_q12(s.log_scale_z);
            a.red = color_q15(s.dc_red);
            a.green = color_q15(s.dc_green);
            a.blue = color_q15(s.dc_blue);
            a.alpha = alpha_q15(s.opacity_logit);
            expected_attr.push_front(a);
        endfunction

        function void check_attr(t_splat_out got);
            t_splat_out want;
            logic bad;
            if (expected_attr.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("unexpected result beat: %p", got);
                end
                return;
            end
            want = expected_attr.pop_back();
            bad = (got.scale_x !== want.scale_x) || (got.scale_y !== want.scale_y) ||
                  (got.scale_z !== want.scale_z) || (got.red !== want.red) ||
                  (got.green !== want.green) || (got.blue !== want.blue) ||
                  (got.alpha !== want.alpha);
            if (bad) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("result mismatch: expected %p", want);
                    $display("                 actual   %p", got);
                end
            end
        endfunction

        function int outstanding();
            return expected_attr.size();
        endfunction
    endclass

    logic       i_clk;
    logic       i_rst_n;
    logic       i_valid;
    logic       o_ready;
    t_splat_in  i_splat;
    logic       o_valid;
    logic       i_ready;
    t_splat_out o_attr;

    activation_scoreboard sb;
    bit quiet;
    int stall_left;
    int unsigned cycles;

    splat_attribute_activation_unit i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_splat (i_splat),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_attr  (o_attr)
    );

    initial begin
        i_clk = 1'b0;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_splat = '0;
        i_ready = 1'b0;
        quiet = 1'b0;
        stall_left = 0;
        cycles = 0;
        sb = new();
    end

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            stall_left--;
            i_ready = 1'b0;
        end else if (!quiet && $urandom_range(0, 11) == 0) begin
            stall_left = $urandom_range(1, 13) - 1;
            i_ready = 1'b0;
        end else begin
            i_ready = 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            sb.check_attr(o_attr);
        end
    end

    function automatic t_splat_in make_splat(int sx, int sy, int sz, int r, int g, int b,
                                             int a);
        t_splat_in s;
        s.log_scale_x = 16'(sx);
        s.log_scale_y = 16'(sy);
        s.log_scale_z = 16'(sz);
        s.dc_red = 16'(r);
        s.dc_green = 16'(g);
        s.dc_blue = 16'(b);
        s.opacity_logit = 16'(a);
        return s;
    endfunction

    function automatic logic [15:0] corner_value();
        case ($urandom_range(0, 9))
            0: return 16'sd0;
            1: return 16'sd1;
            2: return -16'sd1;
            3: return 16'sd32767;
            4: return -16'sd32768;
            5: return 16'sd7260;
            6: return 16'sd7261;
            7: return -16'sd7260;
            8: return -16'sd7261;
            default: return 16'sd4096;
        endcase
    endfunction

    // Mostly full-range fields, some values in the working range, some corners.
    function automatic t_splat_in random_splat();
        t_splat_in s;
        int unsigned mode;
        mode = $urandom_range(0, 19);
        if (mode < 11) begin
            s = make_splat($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                           $urandom);
        end else if (mode < 17) begin
            s = make_splat(int'($urandom_range(0, 24576)) - 12288,
                           int'($urandom_range(0, 24576)) - 12288,
                           int'($urandom_range(0, 24576)) - 12288,
                           int'($urandom_range(0, 16000)) - 8000,
                           int'($urandom_range(0, 16000)) - 8000,
                           int'($urandom_range(0, 16000)) - 8000,
                           int'($urandom_range(0, 49152)) - 24576);
        end else begin
            s = make_splat(corner_value(), corner_value(), corner_value(), corner_value(),
                           corner_value(), corner_value(), corner_value());
        end
        return s;
    endfunction

    task automatic send_splat(input t_splat_in s);
        int gap;
        if (!quiet && $urandom_range(0, 9) == 0) begin
            gap = $urandom_range(1, 13);
            i_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid = 1'b1;
        i_splat = s;
        do @(posedge i_clk); while (!o_ready);
        sb.note_splat(s);
        @(negedge i_clk);
    endtask

    task automatic wait_results_done();
        i_valid = 1'b0;
        while (sb.outstanding() != 0) @(negedge i_clk);
    endtask

    initial begin
        #0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        send_splat(make_splat(0, 0, 0, 0, 0, 0, 0));
        send_splat(make_splat(32767, 32767, 32767, 32767, 32767, 32767, 32767));
        send_splat(make_splat(-32768, -32768, -32768, -32768, -32768, -32768, -32768));
        send_splat(make_splat(-1, -1, -1, -1, -1, -1, -1));
        send_splat(make_splat(1, 1, 1, 1, 1, 1, 1));
        send_splat(make_splat(32767, -32768, 0, 7260, 7261, -7260, 1));
        send_splat(make_splat(-1, 1, 16384, -7261, -7262, 7259, -1));
        send_splat(make_splat(-16384, 8192, -4096, 32767, -32768, 0, 32767));
        send_splat(make_splat(4096, -4096, 12288, 100, -100, 3000, -32768));
        send_splat(make_splat(28672, -8192, 2048, 1, -1, 16384, 4096));
        send_splat(make_splat(-32767, 32766, -2, -16384, 7262, -7259, -4096));
        send_splat(make_splat(20480, -20480, 30000, 0, 0, 0, 8192));
        send_splat(make_splat(16, -16, 256, 2048, -2048, 4096, -8192));
        send_splat(make_splat(-12288, 24576, -24576, -4096, 12000, -12000, 16));
        send_splat(make_splat(8191, -8191, 32000, 5, -5, 7000, -16));
        send_splat(make_splat(0, 0, 0, 0, 0, 0, 32766));
        send_splat(make_splat(0, 0, 0, 0, 0, 0, -32767));
        wait_results_done();

        for (int n = 0; n < RANDOM_BEATS; n++) begin
            if (n == RANDOM_BEATS / 2) begin
                wait_results_done();
            end
            if (n == RANDOM_BEATS - QUIET_BEATS) begin
                quiet = 1'b1;
            end
            send_splat(random_splat());
        end
        i_valid = 1'b0;

        while (sb.outstanding() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (sb.mismatches == 0 && sb.outstanding() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
